// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files; lidar_sector_steering includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== design/lss_pkg.sv =====
`default_nettype none

package lss_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SCAN_W     = 13;
  localparam int DIST_CFG_W = 16;
  localparam int SPEED_W    = 12;
  localparam int RATE_W     = 13;
  localparam int MODE_W     = 2;
  localparam int MUL_B_W    = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_POINTS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd6;

  localparam logic [SCAN_W-1:0]     RST_SCAN_POINTS  = 13'd360;
  localparam logic [DIST_CFG_W-1:0] RST_RANGE_MIN    = 16'd120;
  localparam logic [DIST_CFG_W-1:0] RST_RANGE_MAX    = 16'd12000;
  localparam logic [DIST_CFG_W-1:0] RST_NEAR_LIMIT   = 16'd1000;
  localparam logic [DIST_CFG_W-1:0] RST_FAR_LIMIT    = 16'd2000;
  localparam logic [SPEED_W-1:0]    RST_SLOW_SPEED   = 12'd200;
  localparam logic [SPEED_W-1:0]    RST_CRUISE_SPEED = 12'd500;

  localparam logic [MODE_W-1:0] MODE_NEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Direction scale is twice 6283 so that the divide by 2N rounds half up.
  localparam logic [MUL_B_W-1:0] DIR_SCALE2 = 14'd12566;
  localparam int DIR_OFFSET  = 1571;
  localparam int DEG_ROUND   = 180;
  localparam int DEG_FULL    = 360;
  localparam int MIN_POINTS  = 4;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_BWAIT  = 5'b00010,
    S_DSTART = 5'b00100,
    S_DWAIT  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    B_START  = 2'd0,
    B_STOP   = 2'd1,
    B_FSTART = 2'd2,
    B_FSTOP  = 2'd3
  } bound_t;

  function automatic logic [MUL_B_W-1:0] sector_deg(bound_t b);
    logic [MUL_B_W-1:0] deg;
    unique case (b)
      B_START:  deg = 14'd90;
      B_STOP:   deg = 14'd270;
      B_FSTART: deg = 14'd140;
      B_FSTOP:  deg = 14'd220;
      default:  deg = 14'd90;
    endcase
    return deg;
  endfunction

  function automatic bound_t next_bound(bound_t b);
    bound_t nb;
    unique case (b)
      B_START:  nb = B_STOP;
      B_STOP:   nb = B_FSTART;
      B_FSTART: nb = B_FSTOP;
      B_FSTOP:  nb = B_START;
      default:  nb = B_START;
    endcase
    return nb;
  endfunction

endpackage

`default_nettype wire

// ===== design/lss_div.sv =====
`default_nettype none

module lss_div #(
  parameter int DIVD_W = 27,
  parameter int DIVS_W = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              div_start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   div_busy,
  output logic                   div_done,
  output logic [DIVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W:0]   shifted;
  logic [DIVS_W:0]   diff;

  assign shifted = {rem, quotient[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      cnt      <= '0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        div_busy <= 1'b1;
        cnt      <= CNT_W'(DIVD_W);
      end else if (div_busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // One quotient bit per cycle, restoring form.
  always_ff @(posedge clk) begin
    if (div_start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (div_busy) begin
      if (!diff[DIVS_W]) begin
        rem      <= diff[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lss_track.sv =====
`default_nettype none

module lss_track #(
  parameter int MAX_POINTS = 4096,
  parameter int DIST_WIDTH = 16,
  localparam int IDX_W     = $clog2(MAX_POINTS)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [DIST_WIDTH-1:0]          range_mm,
  input  wire logic                           last_point,
  input  wire logic [lss_pkg::DIST_CFG_W-1:0] range_min_mm,
  input  wire logic [lss_pkg::DIST_CFG_W-1:0] range_max_mm,
  input  wire logic [IDX_W-1:0]               sec_start,
  input  wire logic [IDX_W-1:0]               sec_stop,
  input  wire logic [IDX_W-1:0]               front_start,
  input  wire logic [IDX_W-1:0]               front_stop,
  output logic [lss_pkg::DIST_CFG_W-1:0]      near_distance,
  output logic [IDX_W-1:0]                    near_index,
  output logic [IDX_W-1:0]                    far_index
);

  localparam int DW    = lss_pkg::DIST_CFG_W;
  localparam int CMP_W = (DIST_WIDTH > DW) ? DIST_WIDTH : DW;

  logic [IDX_W-1:0] point_index;
  logic [DW-1:0]    far_distance;
  logic [CMP_W-1:0] range_ext;
  logic             sample_ok;
  logic             scan_first;
  logic [DW-1:0]    base_far_dist;
  logic [DW-1:0]    base_near_dist;
  logic [IDX_W-1:0] base_far_idx;
  logic [IDX_W-1:0] base_near_idx;
  logic             take_far;
  logic             take_near;

  assign range_ext  = CMP_W'(range_mm);
  assign sample_ok  = (range_ext >= CMP_W'(range_min_mm)) &&
                      (range_ext <= CMP_W'(range_max_mm));
  assign scan_first = (point_index == '0);

  // The first sample of a scan compares against fresh starting values.
  assign base_far_dist  = scan_first ? '0 : far_distance;
  assign base_far_idx   = scan_first ? sec_start : far_index;
  assign base_near_dist = scan_first ? range_max_mm : near_distance;
  assign base_near_idx  = scan_first ? sec_start : near_index;

  assign take_far  = sample_ok && (point_index >= sec_start) && (point_index < sec_stop) &&
                     (range_ext > CMP_W'(base_far_dist));
  assign take_near = sample_ok && (point_index >= front_start) &&
                     (point_index < front_stop) && (range_ext < CMP_W'(base_near_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      point_index <= '0;
    end else if (accept) begin
      if (last_point) begin
        point_index <= '0;
      end else if (point_index != IDX_W'(MAX_POINTS - 1)) begin
        point_index <= point_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      far_distance  <= take_far ? range_ext[DW-1:0] : base_far_dist;
      far_index     <= take_far ? point_index : base_far_idx;
      near_distance <= take_near ? range_ext[DW-1:0] : base_near_dist;
      near_index    <= take_near ? point_index : base_near_idx;
    end
  end

endmodule

`default_nettype wire

// ===== design/lidar_sector_steering.sv =====
// Lidar sector steering. Range samples arrive as requests on the input channel
// (in_valid/in_ready), one per sample, indexed from zero by an internal counter;
// last_point closes the scan. A sample that is not the last of its scan leaves
// in_ready high unless scan_points is written, so the next request may follow in
// the next cycle. The last sample starts one direction divide on the shared
// shift-subtract divider, which forms a DIVD_W-bit quotient (DIVD_W is
// clog2(MAX_POINTS + 1) + 14); the steering request then goes to the output
// channel, and in_ready stays low until it is placed in the output register.
// The output register holds a request until out_ready takes it; while it waits,
// further non-last samples are still accepted, and a finished scan waits for it.
// Configuration writes on cfg_write/cfg_index/cfg_data take effect at once.
// After reset, and after every write of scan_points, the four sector bounds are
// recomputed on the same divider, one after another, with in_ready low.
// Reset loads the default configuration, empties the output register and
// restarts the sample counter.
`default_nettype none
`include "assert_macros.svh"

module lidar_sector_steering #(
  parameter int MAX_POINTS = 4096,
  parameter int DIST_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [lss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lss_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [DIST_WIDTH-1:0]          range_mm,
  input  wire logic                           last_point,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lss_pkg::SPEED_W-1:0]         linear_speed_mm_s,
  output logic signed [lss_pkg::RATE_W-1:0]   angular_rate_mrad_s,
  output logic [lss_pkg::MODE_W-1:0]          steer_mode,
  output logic [lss_pkg::DIST_CFG_W-1:0]      front_min_mm
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int N_W    = $clog2(MAX_POINTS + 1);
  localparam int DIVD_W = N_W + lss_pkg::MUL_B_W;
  localparam int DIVS_W = (N_W + 1 > 9) ? N_W + 1 : 9;
  localparam int EXT_W  = (N_W > lss_pkg::SCAN_W) ? N_W : lss_pkg::SCAN_W;
  localparam int QS_W   = DIVD_W + 1;
  localparam int DW     = lss_pkg::DIST_CFG_W;
  localparam int SW     = lss_pkg::SPEED_W;

  logic [lss_pkg::SCAN_W-1:0] cfg_scan_points;
  logic [DW-1:0]              cfg_range_min;
  logic [DW-1:0]              cfg_range_max;
  logic [DW-1:0]              cfg_near_limit;
  logic [DW-1:0]              cfg_far_limit;
  logic [SW-1:0]              cfg_slow_speed;
  logic [SW-1:0]              cfg_cruise_speed;

  lss_pkg::state_t state;
  lss_pkg::state_t state_next;
  lss_pkg::bound_t bsel;
  logic            dirty;
  logic [lss_pkg::MODE_W-1:0] mode;
  logic [lss_pkg::MODE_W-1:0] mode_calc;

  logic [IDX_W-1:0] sec_start;
  logic [IDX_W-1:0] sec_stop;
  logic [IDX_W-1:0] front_start;
  logic [IDX_W-1:0] front_stop;
  logic [DW-1:0]    near_distance;
  logic [IDX_W-1:0] near_index;
  logic [IDX_W-1:0] far_index;

  logic [EXT_W-1:0] sp_ext;
  logic [N_W-1:0]   n_eff;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] off;

  logic                     accept;
  logic                     bound_go;
  logic                     bound_next;
  logic                     dir_op;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [DIVD_W-1:0]        quotient;
  logic [N_W-1:0]           mul_a;
  logic [lss_pkg::MUL_B_W-1:0] mul_b;
  logic [DIVD_W-1:0]        mul_add;
  logic [DIVD_W-1:0]        dividend;
  logic [DIVS_W-1:0]        divisor;

  logic signed [QS_W-1:0] dir_val;
  logic signed [QS_W-1:0] half_val;
  logic signed [QS_W-1:0] rate_full;
  logic                   emit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_scan_points  <= lss_pkg::RST_SCAN_POINTS;
      cfg_range_min    <= lss_pkg::RST_RANGE_MIN;
      cfg_range_max    <= lss_pkg::RST_RANGE_MAX;
      cfg_near_limit   <= lss_pkg::RST_NEAR_LIMIT;
      cfg_far_limit    <= lss_pkg::RST_FAR_LIMIT;
      cfg_slow_speed   <= lss_pkg::RST_SLOW_SPEED;
      cfg_cruise_speed <= lss_pkg::RST_CRUISE_SPEED;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lss_pkg::CFG_SCAN_POINTS:  cfg_scan_points  <= cfg_data[lss_pkg::SCAN_W-1:0];
        lss_pkg::CFG_RANGE_MIN:    cfg_range_min    <= cfg_data[DW-1:0];
        lss_pkg::CFG_RANGE_MAX:    cfg_range_max    <= cfg_data[DW-1:0];
        lss_pkg::CFG_NEAR_LIMIT:   cfg_near_limit   <= cfg_data[DW-1:0];
        lss_pkg::CFG_FAR_LIMIT:    cfg_far_limit    <= cfg_data[DW-1:0];
        lss_pkg::CFG_SLOW_SPEED:   cfg_slow_speed   <= cfg_data[SW-1:0];
        lss_pkg::CFG_CRUISE_SPEED: cfg_cruise_speed <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  assign sp_ext = EXT_W'(cfg_scan_points);

  always_comb begin
    priority if (sp_ext < EXT_W'(lss_pkg::MIN_POINTS)) begin
      n_eff = N_W'(lss_pkg::MIN_POINTS);
    end else if (sp_ext > EXT_W'(MAX_POINTS)) begin
      n_eff = N_W'(MAX_POINTS);
    end else begin
      n_eff = N_W'(sp_ext);
    end
  end

  assign in_ready = (state == lss_pkg::S_IDLE) && !dirty;
  assign accept   = in_valid && in_ready;

  lss_track #(
    .MAX_POINTS (MAX_POINTS),
    .DIST_WIDTH (DIST_WIDTH)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .range_mm      (range_mm),
    .last_point    (last_point),
    .range_min_mm  (cfg_range_min),
    .range_max_mm  (cfg_range_max),
    .sec_start     (sec_start),
    .sec_stop      (sec_stop),
    .front_start   (front_start),
    .front_stop    (front_stop),
    .near_distance (near_distance),
    .near_index    (near_index),
    .far_index     (far_index)
  );

  always_comb begin
    priority if (near_distance <= cfg_near_limit) begin
      mode_calc = lss_pkg::MODE_NEAR;
    end else if (near_distance <= cfg_far_limit) begin
      mode_calc = lss_pkg::MODE_OPEN;
    end else begin
      mode_calc = lss_pkg::MODE_CLEAR;
    end
  end

  assign sel_idx = (mode_calc == lss_pkg::MODE_NEAR) ? near_index : far_index;
  assign off     = (sel_idx >= sec_start) ? sel_idx - sec_start : '0;

  // Divider operands: sector bound is (deg * N + 180) / 360, direction is
  // (off * 12566 + N) / (2 * N). Both share one multiplier in front of the divider.
  assign bound_go   = (state == lss_pkg::S_IDLE) && dirty;
  assign bound_next = (state == lss_pkg::S_BWAIT) && div_done && (bsel != lss_pkg::B_FSTOP);
  assign dir_op     = (state == lss_pkg::S_DSTART);
  assign div_start  = bound_go || bound_next || dir_op;

  assign mul_a    = dir_op ? N_W'(off) : n_eff;
  assign mul_b    = dir_op ? lss_pkg::DIR_SCALE2 :
                    lss_pkg::sector_deg(bound_go ? lss_pkg::B_START :
                                        lss_pkg::next_bound(bsel));
  assign mul_add  = dir_op ? DIVD_W'(n_eff) : DIVD_W'(lss_pkg::DEG_ROUND);
  assign dividend = DIVD_W'(mul_a) * DIVD_W'(mul_b) + mul_add;
  assign divisor  = dir_op ? DIVS_W'({n_eff, 1'b0}) : DIVS_W'(lss_pkg::DEG_FULL);

  lss_div #(
    .DIVD_W (DIVD_W),
    .DIVS_W (DIVS_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .div_start (div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .div_busy  (div_busy),
    .div_done  (div_done),
    .quotient  (quotient)
  );

  assign emit = (state == lss_pkg::S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      lss_pkg::S_IDLE: begin
        if (dirty) begin
          state_next = lss_pkg::S_BWAIT;
        end else if (accept && last_point) begin
          state_next = lss_pkg::S_DSTART;
        end
      end
      lss_pkg::S_BWAIT: begin
        if (div_done && (bsel == lss_pkg::B_FSTOP)) begin
          state_next = lss_pkg::S_IDLE;
        end
      end
      lss_pkg::S_DSTART: state_next = lss_pkg::S_DWAIT;
      lss_pkg::S_DWAIT: begin
        if (div_done) begin
          state_next = lss_pkg::S_EMIT;
        end
      end
      lss_pkg::S_EMIT: begin
        if (emit) begin
          state_next = lss_pkg::S_IDLE;
        end
      end
      default: state_next = lss_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lss_pkg::S_IDLE;
      dirty <= 1'b1;
      bsel  <= lss_pkg::B_START;
    end else begin
      state <= state_next;
      if (cfg_write && (cfg_index == lss_pkg::CFG_SCAN_POINTS)) begin
        dirty <= 1'b1;
      end else if (bound_go) begin
        dirty <= 1'b0;
      end
      if (bound_go) begin
        bsel <= lss_pkg::B_START;
      end else if (bound_next) begin
        bsel <= lss_pkg::next_bound(bsel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lss_pkg::S_BWAIT) && div_done) begin
      unique case (bsel)
        lss_pkg::B_START:  sec_start   <= quotient[IDX_W-1:0];
        lss_pkg::B_STOP:   sec_stop    <= quotient[IDX_W-1:0];
        lss_pkg::B_FSTART: front_start <= quotient[IDX_W-1:0];
        lss_pkg::B_FSTOP:  front_stop  <= quotient[IDX_W-1:0];
        default: ;
      endcase
    end
    if (dir_op) begin
      mode <= mode_calc;
    end
  end

  // Direction in mrad, then the turn rate for the chosen mode.
  assign dir_val  = $signed({1'b0, quotient}) - $signed(QS_W'(lss_pkg::DIR_OFFSET));
  assign half_val = (dir_val + $signed({{(QS_W - 1){1'b0}}, dir_val[QS_W-1]})) >>> 1;

  always_comb begin
    unique case (mode)
      lss_pkg::MODE_NEAR: rate_full = -dir_val;
      lss_pkg::MODE_OPEN: rate_full = half_val;
      default:            rate_full = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      linear_speed_mm_s   <= (mode == lss_pkg::MODE_NEAR) ? cfg_slow_speed : cfg_cruise_speed;
      angular_rate_mrad_s <= rate_full[lss_pkg::RATE_W-1:0];
      steer_mode          <= mode;
      front_min_mm        <= near_distance;
    end
  end

  `ASSERT_NEXT(a_last_starts_dir, clk, rst, accept && last_point, state == lss_pkg::S_DSTART)
  `ASSERT_IMPLY(a_dwait_div_active, clk, rst, state == lss_pkg::S_DWAIT, div_busy || div_done)
  `ASSERT_NEXT(a_points_write_blocks, clk, rst, cfg_write && (cfg_index == lss_pkg::CFG_SCAN_POINTS), !in_ready)
  `ASSERT_IMPLY(a_out_from_emit, clk, rst, $rose(out_valid), $past(state == lss_pkg::S_EMIT))

endmodule

`default_nettype wire
